@@ rtl/hfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hfd_pkg;

    localparam int COUNT_BITS  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [7:0]  CRC_INIT     = 8'hff;
    localparam logic [15:0] RAW_INVALID  = 16'hffff;

    localparam logic [14:0] TEMP_SCALE   = 15'd17500;
    localparam logic [13:0] HUMI_SCALE_A = 14'd10000;
    localparam logic [13:0] HUMI_SCALE_B = 14'd12500;
    localparam logic signed [16:0] TEMP_BIAS   = 17'sd4500;
    localparam logic signed [16:0] HUMI_BIAS_B = 17'sd600;
    localparam logic signed [16:0] HUMI_MAX    = 17'sd9999;
    localparam logic signed [16:0] OFFSET_MUL  = 17'sd10;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SENSOR_TYPE = 2'd0,
        CFG_TEMP_ADJ    = 2'd1,
        CFG_HUMI_ADJ    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        POS_TEMP_HI = 3'd0,
        POS_TEMP_LO = 3'd1,
        POS_CRC     = 3'd2,
        POS_HUMI_HI = 3'd3,
        POS_HUMI_LO = 3'd4
    } pos_t;

    typedef struct packed {
        logic              sensor_type;
        logic signed [7:0] temp_adj;
        logic signed [7:0] humi_adj;
    } cfg_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] raw_temp;
        logic [15:0] raw_humi;
    } frame_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hfd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            q_full,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            frame_start,
    output logic                 push,
    output hfd_pkg::frame_t      push_data
);
    import hfd_pkg::*;

    pos_t        pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] raw_temp_reg, raw_temp_next;
    logic [7:0]  rx_crc_reg, rx_crc_next;
    logic [7:0]  humi_hi_reg, humi_hi_next;
    logic        accept;
    pos_t        pos_eff;

    assign accept  = in_valid && !q_full;
    assign pos_eff = frame_start ? POS_TEMP_HI : pos_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        raw_temp_next = raw_temp_reg;
        rx_crc_next   = rx_crc_reg;
        humi_hi_next  = humi_hi_reg;
        push          = 1'b0;
        push_data.ok       = (crc_reg == rx_crc_reg) && (raw_temp_reg != RAW_INVALID);
        push_data.raw_temp = raw_temp_reg;
        push_data.raw_humi = {humi_hi_reg, rx_byte};
        if (accept)
        begin
            unique case (pos_eff)
                POS_TEMP_LO:
                begin
                    raw_temp_next = {raw_temp_reg[15:8], rx_byte};
                    crc_next      = crc8_byte(crc_reg, rx_byte);
                    pos_next      = POS_CRC;
                end
                POS_CRC:
                begin
                    rx_crc_next = rx_byte;
                    pos_next    = POS_HUMI_HI;
                end
                POS_HUMI_HI:
                begin
                    humi_hi_next = rx_byte;
                    pos_next     = POS_HUMI_LO;
                end
                POS_HUMI_LO:
                begin
                    push     = 1'b1;
                    crc_next = CRC_INIT;
                    pos_next = POS_TEMP_HI;
                end
                default:
                begin
                    crc_next      = crc8_byte(CRC_INIT, rx_byte);
                    raw_temp_next = {rx_byte, 8'h00};
                    pos_next      = POS_TEMP_LO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_TEMP_HI;
            crc_reg      <= CRC_INIT;
            raw_temp_reg <= '0;
            rx_crc_reg   <= '0;
            humi_hi_reg  <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            raw_temp_reg <= raw_temp_next;
            rx_crc_reg   <= rx_crc_next;
            humi_hi_reg  <= humi_hi_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hfd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hfd_pkg::frame_t push_data,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output hfd_pkg::frame_t      head
);
    import hfd_pkg::*;

    frame_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hfd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hfd_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hfd_pkg::cfg_t         cfg,
    input  wire logic                  q_not_empty,
    input  wire hfd_pkg::frame_t       q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       frame_ok,
    output logic signed [14:0]         temperature,
    output logic [13:0]                humidity,
    output logic [7:0]                 good_count
);
    import hfd_pkg::*;

    // scaling stage
    logic                   a_valid_reg;
    logic                   a_ok_reg;
    logic [14:0]            a_temp_reg, a_temp_next;
    logic [13:0]            a_humi_reg, a_humi_next;
    logic [30:0]            prod_t;
    logic [29:0]            prod_h;
    logic                   a_load;

    // output stage
    logic                   out_valid_reg;
    logic                   ok_reg;
    logic signed [14:0]     temp_reg;
    logic [13:0]            humi_reg;
    logic [7:0]             good_reg;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   out_load;

    logic signed [16:0]     t_sum;
    logic signed [16:0]     h_sum;
    logic [13:0]            h_sat;

    assign out_load = a_valid_reg && (!out_valid_reg || !out_stall);
    assign a_load   = !a_valid_reg || out_load;
    assign q_pop    = a_load && q_not_empty;

    always_comb
    begin
        prod_t      = 31'(q_head.raw_temp) * 31'(TEMP_SCALE);
        prod_h      = 30'(q_head.raw_humi) *
                      30'(cfg.sensor_type ? HUMI_SCALE_B : HUMI_SCALE_A);
        a_temp_next = prod_t[30:16];
        a_humi_next = prod_h[29:16];
    end

    always_comb
    begin
        t_sum = $signed({2'b00, a_temp_reg}) - TEMP_BIAS +
                17'(cfg.temp_adj) * OFFSET_MUL;
        h_sum = $signed({3'b000, a_humi_reg}) - (cfg.sensor_type ? HUMI_BIAS_B : 17'sd0) +
                17'(cfg.humi_adj) * OFFSET_MUL;
        if (h_sum < 17'sd0)
        begin
            h_sat = '0;
        end
        else if (h_sum > HUMI_MAX)
        begin
            h_sat = HUMI_MAX[13:0];
        end
        else
        begin
            h_sat = h_sum[13:0];
        end
        count_next = count_reg + (a_ok_reg ? COUNT_BITS'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_ok_reg   <= q_head.ok;
            a_temp_reg <= a_temp_next;
            a_humi_reg <= a_humi_next;
        end
        if (out_load)
        begin
            ok_reg   <= a_ok_reg;
            temp_reg <= a_ok_reg ? t_sum[14:0] : '0;
            humi_reg <= a_ok_reg ? h_sat : '0;
            good_reg <= count_next[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= q_not_empty;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_ok    = ok_reg;
    assign temperature = temp_reg;
    assign humidity    = humi_reg;
    assign good_count  = good_reg;

endmodule

`default_nettype wire

@@ rtl/humidity_sensor_frame_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Decodes five-byte sensor frames (temperature high, temperature low, CRC-8 over
// the temperature, humidity high, humidity low) into a frame_ok flag, temperature
// in 0.01 C, humidity in 0.01 % saturated to 0..9999, and a running count of good
// frames. One byte is accepted per clock while in_stall is low; a frame_start beat
// drops any partial frame and restarts the byte position. The fifth byte of a frame
// yields one result beat on out_valid, passing from the frame queue through the
// scaling multipliers and scaling register, then the offset and saturation stage
// ahead of the output register. A two-entry queue parts the byte decoder from the
// scaling stages, so results that wait on out_stall do not hold up the input until
// the queue fills. Configuration (index 0 sensor type, 1 temperature offset, 2
// humidity offset, offsets in 0.1 units) is always ready and should be written
// while no frame is in flight.
module humidity_sensor_frame_decoder_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                frame_start,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     frame_ok,
    output logic signed [14:0]       temperature,
    output logic [13:0]              humidity,
    output logic [7:0]               good_count,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);
    import hfd_pkg::*;

    cfg_t   cfg_reg;
    frame_t push_data;
    frame_t q_head;
    logic   push;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SENSOR_TYPE: cfg_reg.sensor_type <= cfg_data[0];
                CFG_TEMP_ADJ:    cfg_reg.temp_adj    <= cfg_data;
                CFG_HUMI_ADJ:    cfg_reg.humi_adj    <= cfg_data;
                default: ;
            endcase
        end
    end

    hfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .q_full      (q_full),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .push        (push),
        .push_data   (push_data)
    );

    hfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    hfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_ok    (frame_ok),
        .temperature (temperature),
        .humidity    (humidity),
        .good_count  (good_count)
    );

endmodule

`default_nettype wire
